/* sv/itp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_pkg: shared types and constants of the infix-to-postfix converter
// Token codes, result codes, priority set and the queued command format.
// ----------------------------------------------------------------------------
package itp_pkg;

    // default operator stack depth
    localparam int STACK_DEPTH_DEF = 16;

    // input action codes
    localparam logic [2:0] ACT_OPERAND = 3'd0;
    localparam logic [2:0] ACT_OPEN    = 3'd1;
    localparam logic [2:0] ACT_CLOSE   = 3'd2;
    localparam logic [2:0] ACT_OPER    = 3'd3;
    localparam logic [2:0] ACT_END     = 3'd4;

    // operator codes that select a priority class, and the last valid code
    localparam logic [3:0] OP_ADD   = 4'd0;
    localparam logic [3:0] OP_SUB   = 4'd1;
    localparam logic [3:0] OP_EQ    = 4'd4;
    localparam logic [3:0] OP_CARET = 4'd5;
    localparam logic [3:0] OP_LAST  = 4'd11;

    // stack entry marking an open parenthesis
    localparam logic [3:0] PAREN_MARK = 4'hF;

    // result kinds
    localparam logic [1:0] KIND_OPERAND  = 2'd0;
    localparam logic [1:0] KIND_OPERATOR = 2'd1;
    localparam logic [1:0] KIND_NONE     = 2'd2;

    // error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_CLOSE    = 2'd1;
    localparam logic [1:0] ERR_OPEN     = 2'd2;
    localparam logic [1:0] ERR_OVERFLOW = 2'd3;

    // register indexes
    localparam logic [1:0] REG_PRIO_EQUAL   = 2'd0;
    localparam logic [1:0] REG_PRIO_ADD_SUB = 2'd1;
    localparam logic [1:0] REG_PRIO_MUL     = 2'd2;
    localparam logic [1:0] REG_PRIO_POWER   = 2'd3;

    // register reset values
    localparam logic [2:0] PRIO_EQUAL_RST   = 3'd2;
    localparam logic [2:0] PRIO_ADD_SUB_RST = 3'd3;
    localparam logic [2:0] PRIO_MUL_RST     = 3'd4;
    localparam logic [2:0] PRIO_POWER_RST   = 3'd6;

    typedef struct packed {
        logic [2:0] prio_equal;
        logic [2:0] prio_add_sub;
        logic [2:0] prio_mul_div_func;
        logic [2:0] prio_power;
    } prio_cfg_t;

    typedef enum logic [2:0] {
        CMD_OPERAND,
        CMD_OPEN,
        CMD_CLOSE,
        CMD_OPER,
        CMD_END
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [3:0]  op;
        logic [31:0] value;
    } cmd_t;

    // priority of an operator code
    function automatic logic [2:0] prio_of(input logic [3:0] op, input prio_cfg_t cfg);
        logic [2:0] p;
        case (op)
            OP_ADD, OP_SUB: p = cfg.prio_add_sub;
            OP_EQ:          p = cfg.prio_equal;
            OP_CARET:       p = cfg.prio_power;
            default:        p = cfg.prio_mul_div_func;
        endcase
        return p;
    endfunction

endpackage

/* sv/infix_to_postfix_converter_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_core: shunting-yard token converter
// An accepted item passes the command queue register, then the result register.
// An item takes 1 + k stack steps, k being its popped operators (max(1, k)
// for an end item); one stack step per cycle while results do not stall.
// A two-entry command queue lets input items be taken while results stall.
// Reset (aresetn, synchronous): empty stack and queue, default priorities.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_core #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [3:0] op_code, [35:4] operand_value, zero pad
    input  logic [2:0]  s_tuser,   // [2:0] action
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [3:0] out_op, [35:4] out_value, [37:36] error
    output logic [1:0]  m_tuser,   // [1:0] out_kind
    output logic        m_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    itp_pkg::prio_cfg_t cfg_reg;
    logic               cfg_wr;
    logic               cmd_valid, cmd_pop;
    itp_pkg::cmd_t      cmd;
    logic [1:0]         out_kind, out_error;
    logic [3:0]         out_op;
    logic [31:0]        out_value;

    // register write and read
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.prio_equal        <= itp_pkg::PRIO_EQUAL_RST;
            cfg_reg.prio_add_sub      <= itp_pkg::PRIO_ADD_SUB_RST;
            cfg_reg.prio_mul_div_func <= itp_pkg::PRIO_MUL_RST;
            cfg_reg.prio_power        <= itp_pkg::PRIO_POWER_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                itp_pkg::REG_PRIO_EQUAL:   cfg_reg.prio_equal        <= pwdata[2:0];
                itp_pkg::REG_PRIO_ADD_SUB: cfg_reg.prio_add_sub      <= pwdata[2:0];
                itp_pkg::REG_PRIO_MUL:     cfg_reg.prio_mul_div_func <= pwdata[2:0];
                itp_pkg::REG_PRIO_POWER:   cfg_reg.prio_power        <= pwdata[2:0];
                default:                   cfg_reg.prio_equal        <= pwdata[2:0];
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            itp_pkg::REG_PRIO_EQUAL:   prdata = {29'd0, cfg_reg.prio_equal};
            itp_pkg::REG_PRIO_ADD_SUB: prdata = {29'd0, cfg_reg.prio_add_sub};
            itp_pkg::REG_PRIO_MUL:     prdata = {29'd0, cfg_reg.prio_mul_div_func};
            itp_pkg::REG_PRIO_POWER:   prdata = {29'd0, cfg_reg.prio_power};
            default:                   prdata = 32'd0;
        endcase
    end

    // classifier and queue
    itp_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .action        (s_tuser),
        .op_code       (s_tdata[3:0]),
        .operand_value (s_tdata[35:4]),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop)
    );

    // stack engine
    itp_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .prio_cfg  (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .out_kind  (out_kind),
        .out_op    (out_op),
        .out_value (out_value),
        .out_error (out_error),
        .out_last  (m_tlast)
    );

    // result packing
    assign m_tdata = {2'd0, out_error, out_value, out_op};
    assign m_tuser = out_kind;

endmodule

/* sv/itp_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data (old data on
// a same-address read and write).
// ----------------------------------------------------------------------------
module itp_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/itp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_front: token classifier and command queue
// Decodes each input item into a stack command, drops ignored tokens and
// buffers commands in a two-entry queue for the stack engine.
// ----------------------------------------------------------------------------
module itp_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        action,
    input  logic [3:0]        op_code,
    input  logic [31:0]       operand_value,
    output logic              cmd_valid,
    output itp_pkg::cmd_t     cmd,
    input  logic              cmd_pop
);

    logic                 keep;
    itp_pkg::cmd_t        cmd_in;
    logic                 push;
    itp_pkg::cmd_t        entry_reg [2];
    logic                 wr_ptr_reg, wr_ptr_next;
    logic                 rd_ptr_reg, rd_ptr_next;
    logic [1:0]           fill_reg, fill_next;

    // classify the token
    always_comb begin
        keep          = 1'b1;
        cmd_in.kind   = itp_pkg::CMD_OPERAND;
        cmd_in.op     = op_code;
        cmd_in.value  = operand_value;
        case (action)
            itp_pkg::ACT_OPERAND: cmd_in.kind = itp_pkg::CMD_OPERAND;
            itp_pkg::ACT_OPEN:    cmd_in.kind = itp_pkg::CMD_OPEN;
            itp_pkg::ACT_CLOSE:   cmd_in.kind = itp_pkg::CMD_CLOSE;
            itp_pkg::ACT_OPER: begin
                cmd_in.kind = itp_pkg::CMD_OPER;
                keep        = (op_code <= itp_pkg::OP_LAST);
            end
            itp_pkg::ACT_END:     cmd_in.kind = itp_pkg::CMD_END;
            default:              keep = 1'b0;
        endcase
    end

    // queue pointers and fill level
    always_comb begin
        in_ready    = (fill_reg != 2'd2);
        push        = in_valid && in_ready && keep;
        cmd_valid   = (fill_reg != 2'd0);
        cmd         = entry_reg[rd_ptr_reg];
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, cmd_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

/* sv/itp_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_back: operator stack engine
// Runs queued commands one stack step per cycle unless results stall:
// pushes, pops with priority compare, flushes and error clears, into a result register.
// ----------------------------------------------------------------------------
module itp_back #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  itp_pkg::prio_cfg_t   prio_cfg,
    input  logic                 cmd_valid,
    input  itp_pkg::cmd_t        cmd,
    output logic                 cmd_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [1:0]           out_kind,
    output logic [3:0]           out_op,
    output logic [31:0]          out_value,
    output logic [1:0]           out_error,
    output logic                 out_last
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

    // stack state: top entry in a register, the rest in RAM
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] paren_reg, paren_next;
    logic [3:0]    tos_reg, tos_next;
    logic          byp_reg, byp_next;
    logic [3:0]    byp_data_reg;

    // result register
    logic          valid_reg;
    logic [1:0]    kind_reg;
    logic [3:0]    op_reg;
    logic [31:0]   value_reg;
    logic [1:0]    err_reg;
    logic          last_reg;

    logic          step, done, emit;
    logic [1:0]    e_kind, e_err;
    logic [3:0]    e_op;
    logic [31:0]   e_val;
    logic          e_last;
    logic          do_push, do_pop, do_clear;
    logic [3:0]    push_val;
    logic [3:0]    below;
    logic          tos_paren, below_paren;
    logic [2:0]    op_prio;
    logic          tos_ge, below_ge;
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [3:0]    ram_rdata;

    itp_ram #(
        .WIDTH (4),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (tos_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // compare values for the top two entries
    always_comb begin
        below       = byp_reg ? byp_data_reg : ram_rdata;
        tos_paren   = (tos_reg == itp_pkg::PAREN_MARK);
        below_paren = (below == itp_pkg::PAREN_MARK);
        op_prio     = itp_pkg::prio_of(cmd.op, prio_cfg);
        tos_ge      = (op_prio <= itp_pkg::prio_of(tos_reg, prio_cfg));
        below_ge    = (op_prio <= itp_pkg::prio_of(below, prio_cfg));
    end

    // one stack step of the head command
    always_comb begin
        step     = cmd_valid && (!valid_reg || m_tready);
        done     = 1'b0;
        emit     = 1'b0;
        e_kind   = itp_pkg::KIND_NONE;
        e_op     = 4'd0;
        e_val    = 32'd0;
        e_err    = itp_pkg::ERR_NONE;
        e_last   = 1'b1;
        do_push  = 1'b0;
        do_pop   = 1'b0;
        do_clear = 1'b0;
        push_val = cmd.op;
        if (step) begin
            case (cmd.kind)
                itp_pkg::CMD_OPERAND: begin
                    emit   = 1'b1;
                    e_kind = itp_pkg::KIND_OPERAND;
                    e_val  = cmd.value;
                    done   = 1'b1;
                end
                itp_pkg::CMD_OPEN: begin
                    done = 1'b1;
                    if (count_reg == FULL) begin
                        emit     = 1'b1;
                        e_err    = itp_pkg::ERR_OVERFLOW;
                        do_clear = 1'b1;
                    end else begin
                        do_push  = 1'b1;
                        push_val = itp_pkg::PAREN_MARK;
                    end
                end
                itp_pkg::CMD_CLOSE: begin
                    if (paren_reg == '0) begin
                        emit     = 1'b1;
                        e_err    = itp_pkg::ERR_CLOSE;
                        do_clear = 1'b1;
                        done     = 1'b1;
                    end else if (!tos_paren) begin
                        // the match lies below, so count is at least two
                        emit   = 1'b1;
                        e_kind = itp_pkg::KIND_OPERATOR;
                        e_op   = tos_reg;
                        e_last = below_paren;
                        do_pop = 1'b1;
                    end else begin
                        do_pop = 1'b1;
                        done   = 1'b1;
                    end
                end
                itp_pkg::CMD_OPER: begin
                    if (count_reg != '0 && !tos_paren && tos_ge) begin
                        emit   = 1'b1;
                        e_kind = itp_pkg::KIND_OPERATOR;
                        e_op   = tos_reg;
                        e_last = !(count_reg > CW'(1) && !below_paren && below_ge);
                        do_pop = 1'b1;
                    end else if (count_reg == FULL) begin
                        emit     = 1'b1;
                        e_err    = itp_pkg::ERR_OVERFLOW;
                        do_clear = 1'b1;
                        done     = 1'b1;
                    end else begin
                        do_push = 1'b1;
                        done    = 1'b1;
                    end
                end
                itp_pkg::CMD_END: begin
                    emit = 1'b1;
                    if (paren_reg != '0) begin
                        e_err    = itp_pkg::ERR_OPEN;
                        do_clear = 1'b1;
                        done     = 1'b1;
                    end else if (count_reg == '0) begin
                        done = 1'b1;
                    end else begin
                        e_kind = itp_pkg::KIND_OPERATOR;
                        e_op   = tos_reg;
                        e_last = (count_reg == CW'(1));
                        done   = (count_reg == CW'(1));
                        do_pop = 1'b1;
                    end
                end
                default: done = 1'b1;
            endcase
        end
        cmd_pop = step && done;
    end

    // stack update
    always_comb begin
        count_next = count_reg;
        paren_next = paren_reg;
        tos_next   = tos_reg;
        if (do_clear) begin
            count_next = '0;
            paren_next = '0;
        end else if (do_push) begin
            count_next = count_reg + CW'(1);
            tos_next   = push_val;
            if (push_val == itp_pkg::PAREN_MARK) begin
                paren_next = paren_reg + CW'(1);
            end
        end else if (do_pop) begin
            count_next = count_reg - CW'(1);
            tos_next   = below;
            if (tos_paren) begin
                paren_next = paren_reg - CW'(1);
            end
        end
        // old top spills into RAM at count-1, which is the next read address
        ram_we    = do_push && (count_reg != '0);
        ram_waddr = AW'(count_reg - CW'(1));
        ram_raddr = (count_next >= CW'(2)) ? AW'(count_next - CW'(2)) : '0;
        byp_next  = ram_we;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            paren_reg <= '0;
            byp_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            paren_reg <= paren_next;
            byp_reg   <= byp_next;
            if (emit) begin
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        tos_reg      <= tos_next;
        byp_data_reg <= tos_reg;
        if (emit) begin
            kind_reg  <= e_kind;
            op_reg    <= e_op;
            value_reg <= e_val;
            err_reg   <= e_err;
            last_reg  <= e_last;
        end
    end

    assign m_tvalid  = valid_reg;
    assign out_kind  = kind_reg;
    assign out_op    = op_reg;
    assign out_value = value_reg;
    assign out_error = err_reg;
    assign out_last  = last_reg;

    // open parens on the stack never outnumber its entries
    a_paren_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        paren_reg <= count_reg && count_reg <= FULL)
        else $error("paren count exceeds stack count");

    // the stack moves by one entry per cycle or is cleared
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> (count_reg == '0 || count_reg == $past(count_reg) ||
                  count_reg == $past(count_reg) + CW'(1) ||
                  count_reg == $past(count_reg) - CW'(1)))
        else $error("stack count jumped");

    // an error result carries no token and ends its item
    a_err_result: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && err_reg != itp_pkg::ERR_NONE |->
            kind_reg == itp_pkg::KIND_NONE && last_reg)
        else $error("error on a token result");

    // a parenthesis mark is never emitted as an operator
    a_no_paren_out: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && kind_reg == itp_pkg::KIND_OPERATOR |->
            op_reg != itp_pkg::PAREN_MARK)
        else $error("paren mark emitted");

endmodule
